@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define LBS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("lbs assertion failed");

// Clocked assertion that also runs during reset.
`define LBS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("lbs assertion failed");

`endif

@@ hdl/lbs_pkg.sv @@
// Types and constants of the character LCD bus sequencer.
`default_nettype none
package lbs_pkg;

    // command codes
    localparam logic [1:0] CMD_INIT    = 2'd0;
    localparam logic [1:0] CMD_WR_INSTR = 2'd1;
    localparam logic [1:0] CMD_WR_DATA = 2'd2;
    localparam logic [1:0] CMD_SET_POS = 2'd3;

    // configuration register indexes
    localparam int NUM_CFG = 8;
    localparam logic [2:0] CFG_FOUR_BIT  = 3'd0;
    localparam logic [2:0] CFG_TWO_LINES = 3'd1;
    localparam logic [2:0] CFG_TALL_FONT = 3'd2;
    localparam logic [2:0] CFG_DISP_ON   = 3'd3;
    localparam logic [2:0] CFG_CURSOR_ON = 3'd4;
    localparam logic [2:0] CFG_BLINK_ON  = 3'd5;
    localparam logic [2:0] CFG_ADDR_INC  = 3'd6;
    localparam logic [2:0] CFG_DISP_SHIFT = 3'd7;
    // reset image, bit i is register i
    localparam logic [NUM_CFG-1:0] CFG_RESET = 8'b0100_1011;

    // bus constants
    localparam logic [6:0] IDLE_MS      = 7'd35;
    localparam logic [7:0] FUNC_SET_8   = 8'h38;
    localparam logic [7:0] FUNC_SET_4   = 8'h20;
    localparam logic [7:0] WAKE_NIBBLE  = 8'h20;
    localparam logic [7:0] DISP_CTRL    = 8'h08;
    localparam logic [7:0] CLEAR_DISP   = 8'h01;
    localparam logic [7:0] ENTRY_MODE   = 8'h04;
    localparam logic [7:0] DDRAM_ROW1   = 8'h80;
    localparam logic [7:0] DDRAM_ROW2   = 8'hC0;
    localparam logic [1:0] ROW_FIRST    = 2'd1;
    localparam logic [1:0] ROW_SECOND   = 2'd2;

    // init byte slots
    localparam logic [1:0] INIT_FUNC  = 2'd0;
    localparam logic [1:0] INIT_DISP  = 2'd1;
    localparam logic [1:0] INIT_CLEAR = 2'd2;
    localparam logic [1:0] INIT_ENTRY = 2'd3;

    typedef struct packed {
        logic four_bit_bus;
        logic two_lines;
        logic tall_font;
        logic display_on;
        logic cursor_on;
        logic blink_on;
        logic address_increment;
        logic display_shift;
    } t_cfg;

    // classified work item passed from front to back
    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] byte_val;
    } t_job;

    // one bus state
    typedef struct packed {
        logic       rs;
        logic       en;
        logic [7:0] data;
        logic [6:0] hold_ms;
        logic       last;
    } t_result;

    // settling delay after each init byte
    function automatic logic [1:0] init_extra(input logic [1:0] slot);
        logic [1:0] ext;
        case (slot)
            INIT_FUNC:  ext = 2'd1;
            INIT_DISP:  ext = 2'd1;
            INIT_CLEAR: ext = 2'd2;
            default:    ext = 2'd0;
        endcase
        return ext;
    endfunction

endpackage
`default_nettype wire

@@ hdl/lbs_fifo.sv @@
// Small first-word-fall-through queue.
`default_nettype none
module lbs_fifo #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

@@ hdl/lbs_front.sv @@
// Front end: classifies commands into byte or init jobs, drops bad positions.
`default_nettype none
module lbs_front
    import lbs_pkg::*;
#(
    parameter int COLUMNS = 16
) (
    input  wire logic [1:0] i_command,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [1:0] i_row,
    input  wire logic [4:0] i_column,
    output t_job            o_job,
    output logic            o_job_valid
);
    logic       pos_ok;
    logic [7:0] pos_byte;

    // column 0 is out of range as well
    assign pos_ok = ((i_row == ROW_FIRST) || (i_row == ROW_SECOND)) &&
                    (i_column != 5'd0) && (6'(i_column) <= 6'(COLUMNS));
    assign pos_byte = ((i_row == ROW_FIRST) ? DDRAM_ROW1 : DDRAM_ROW2) +
                      8'(i_column) - 8'd1;

    always_comb begin
        o_job       = '0;
        o_job_valid = 1'b1;
        case (i_command)
            CMD_INIT: begin
                o_job.is_init = 1'b1;
            end
            CMD_WR_INSTR: begin
                o_job.byte_val = i_data_byte;
            end
            CMD_WR_DATA: begin
                o_job.rs       = 1'b1;
                o_job.byte_val = i_data_byte;
            end
            default: begin
                o_job.byte_val = pos_byte;
                o_job_valid    = pos_ok;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/lbs_back.sv @@
// Back end: steps through the bus states of one job, one state per cycle while the result queue has room.
`default_nettype none
module lbs_back
    import lbs_pkg::*;
#(
    parameter int PULSE_MS = 5
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg    i_cfg,
    input  wire t_job    i_job,
    input  wire logic    i_job_valid,
    output logic         o_job_pop,
    input  wire logic    i_res_full,
    output logic         o_res_push,
    output t_result      o_res
);
    localparam logic [6:0] PULSE = 7'(PULSE_MS);

    logic [4:0] r_step;
    logic [7:0] r_data_level;

    logic [4:0] s;
    logic [1:0] slot, p, extra;
    logic [7:0] byte_sel, init_byte;
    logic       ph_final;
    logic       four;

    assign four = i_cfg.four_bit_bus;

    always_comb begin
        // index into the byte slots of the init sequence
        s = four ? (r_step - 5'd3) : (r_step - 5'd1);
        if (i_job.is_init) begin
            slot = four ? s[3:2] : s[2:1];
            p    = four ? s[1:0] : {1'b0, s[0]};
        end else begin
            slot = INIT_FUNC;
            p    = four ? r_step[1:0] : {1'b0, r_step[0]};
        end

        case (slot)
            INIT_FUNC:  init_byte = four ? (FUNC_SET_4 | {4'd0, i_cfg.two_lines,
                                                          i_cfg.tall_font, 2'd0})
                                         : FUNC_SET_8;
            INIT_DISP:  init_byte = DISP_CTRL | {5'd0, i_cfg.display_on,
                                                 i_cfg.cursor_on, i_cfg.blink_on};
            INIT_CLEAR: init_byte = CLEAR_DISP;
            default:    init_byte = ENTRY_MODE | {6'd0, i_cfg.address_increment,
                                                  i_cfg.display_shift};
        endcase

        byte_sel = i_job.is_init ? init_byte : i_job.byte_val;
        extra    = i_job.is_init ? init_extra(slot) : 2'd0;
        ph_final = four ? (p == 2'd3) : p[0];

        o_res    = '0;
        o_res.en = ~p[0];
        o_res.data = four ? (p[1] ? {byte_sel[3:0], 4'd0} : {byte_sel[7:4], 4'd0})
                          : byte_sel;
        o_res.hold_ms = PULSE + (ph_final ? 7'(extra) : 7'd0);
        o_res.rs   = i_job.is_init ? 1'b0 : i_job.rs;
        o_res.last = ph_final && (!i_job.is_init || slot == INIT_ENTRY);

        if (i_job.is_init && r_step == 5'd0) begin
            // idle state, pins hold their last level
            o_res.en      = 1'b0;
            o_res.data    = r_data_level;
            o_res.hold_ms = four ? IDLE_MS : {IDLE_MS[5:0], 1'b0};
            o_res.last    = 1'b0;
        end else if (i_job.is_init && four && r_step <= 5'd2) begin
            // lone wake-up nibble
            o_res.en      = (r_step == 5'd1);
            o_res.data    = WAKE_NIBBLE;
            o_res.hold_ms = PULSE;
            o_res.last    = 1'b0;
        end
    end

    assign o_res_push = i_job_valid && !i_res_full;
    assign o_job_pop  = o_res_push && o_res.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= '0;
            r_data_level <= '0;
        end else if (o_res_push) begin
            r_step       <= o_res.last ? 5'd0 : r_step + 5'd1;
            r_data_level <= o_res.data;
        end
    end

endmodule
`default_nettype wire

@@ hdl/character_lcd_bus_sequencer_core.sv @@
// Top level of the character LCD bus sequencer.
// Takes LCD commands (init, instruction write, data write, set position) on a
// push/full queue port and gives timed bus states (RS, EN, D7..D0, hold time in
// ms, last flag) on an empty/pop queue port. A front end classifies each item
// and drops out-of-range positions (row not 1-2, column 0 or above COLUMNS),
// which give no bus states. A two-entry job queue feeds the back-end
// sequencer, which emits one bus state per clock into a two-entry result
// queue while that queue has room, so items are accepted while results still
// wait. A byte write gives 4 bus states in 4-bit mode and 2 in 8-bit mode;
// init gives 19 in 4-bit mode and 9 in 8-bit mode. An accepted item is
// registered in the job queue, and its first bus state is then registered in
// the result queue once the items ahead of it are done and the queue has room;
// it can be popped from there.
// Configuration registers are written on the plain write port and must only
// change while the block is idle; writes use the bus mode selected now.
`default_nettype none
module character_lcd_bus_sequencer_core
    import lbs_pkg::*;
#(
    parameter int PULSE_MS = 5,
    parameter int COLUMNS  = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // command queue
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [1:0] i_command,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [1:0] i_row,
    input  wire logic [4:0] i_column,
    // bus state queue
    output logic            o_empty,
    input  wire logic       i_pop,
    output logic            o_rs_pin,
    output logic            o_en_pin,
    output logic [7:0]      o_data_pins,
    output logic [6:0]      o_hold_ms,
    output logic            o_last,
    // configuration
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_idx,
    input  wire logic [0:0] i_cfg_data
);
    localparam int JOB_W = $bits(t_job);
    localparam int RES_W = $bits(t_result);

    logic [NUM_CFG-1:0] r_cfg;
    t_cfg               cfg;

    t_job    fr_job, q_job;
    logic    fr_valid, jq_full, jq_empty, jq_pop;
    t_result bk_res, rq_res;
    logic    rq_full, bk_push;

    // config registers, bit i is register i
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data[0];
        end
    end

    always_comb begin
        cfg.four_bit_bus      = r_cfg[CFG_FOUR_BIT];
        cfg.two_lines         = r_cfg[CFG_TWO_LINES];
        cfg.tall_font         = r_cfg[CFG_TALL_FONT];
        cfg.display_on        = r_cfg[CFG_DISP_ON];
        cfg.cursor_on         = r_cfg[CFG_CURSOR_ON];
        cfg.blink_on          = r_cfg[CFG_BLINK_ON];
        cfg.address_increment = r_cfg[CFG_ADDR_INC];
        cfg.display_shift     = r_cfg[CFG_DISP_SHIFT];
    end

    // front: classify the item
    lbs_front #(
        .COLUMNS (COLUMNS)
    ) u_front (
        .i_command   (i_command),
        .i_data_byte (i_data_byte),
        .i_row       (i_row),
        .i_column    (i_column),
        .o_job       (fr_job),
        .o_job_valid (fr_valid)
    );

    // job queue; a dropped item is accepted but never enqueued
    assign o_full = jq_full;

    lbs_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && fr_valid),
        .i_data  (fr_job),
        .o_full  (jq_full),
        .i_pop   (jq_pop),
        .o_data  (q_job),
        .o_empty (jq_empty)
    );

    // back: sequence bus states
    lbs_back #(
        .PULSE_MS (PULSE_MS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job       (q_job),
        .i_job_valid (!jq_empty),
        .o_job_pop   (jq_pop),
        .i_res_full  (rq_full),
        .o_res_push  (bk_push),
        .o_res       (bk_res)
    );

    // result queue
    lbs_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (bk_push),
        .i_data  (bk_res),
        .o_full  (rq_full),
        .i_pop   (i_pop),
        .o_data  (rq_res),
        .o_empty (o_empty)
    );

    assign o_rs_pin    = rq_res.rs;
    assign o_en_pin    = rq_res.en;
    assign o_data_pins = rq_res.data;
    assign o_hold_ms   = rq_res.hold_ms;
    assign o_last      = rq_res.last;

endmodule
`default_nettype wire

@@ hdl/lbs_checker.sv @@
// Port-level checks of the sequencer core and their bind.
`default_nettype none
`include "assert_macros.svh"
module lbs_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_full,
    input wire logic       o_empty,
    input wire logic       i_pop,
    input wire logic       o_rs_pin,
    input wire logic       o_en_pin,
    input wire logic [7:0] o_data_pins,
    input wire logic [6:0] o_hold_ms,
    input wire logic       o_last
);
    // every bus state is held for some time
    `LBS_ASSERT(a_hold_nonzero, i_clk, i_rst_n, !o_empty |-> (o_hold_ms != 7'd0))
    // a strobe always ends low, so EN high is never the last state
    `LBS_ASSERT(a_en_not_last, i_clk, i_rst_n, (!o_empty && o_en_pin) |-> !o_last)
    // queues come out of reset empty
    `LBS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (o_empty && !o_full))
    // a waiting bus state holds until taken
    `LBS_ASSERT(a_stall_hold, i_clk, i_rst_n, (!o_empty && !i_pop) |=> (!o_empty && $stable(o_rs_pin) && $stable(o_en_pin) && $stable(o_data_pins) && $stable(o_hold_ms) && $stable(o_last)))

endmodule

bind character_lcd_bus_sequencer_core lbs_checker u_checker (.*);
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the character LCD bus sequencer core.
`timescale 1ns / 100ps
module tb_top;
    import lbs_pkg::*;

    localparam int PULSE_MS  = 5;
    localparam int COLUMNS   = 16;
    localparam int CLK_HALF  = 5;
    // Idle time before a register write, taken after the last expected bus state
    // has come out; dropped items are never enqueued, so they leave nothing behind.
    localparam int SETTLE    = 40;
    // Worst case is roughly 123 items x 19 states with random pop stalls,
    // plus push gaps and phase pauses; this is several times that.
    localparam int MAX_CYCLES = 500000;
    localparam int RAND_PHASES = 5;
    localparam int RAND_ITEMS  = 20;

    // one LCD command as it goes into the block
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic [1:0] row;
        logic [4:0] column;
    } t_lcd_cmd;

    // DUT ports
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_push      = 1'b0;
    logic       o_full;
    logic [1:0] i_command   = '0;
    logic [7:0] i_data_byte = '0;
    logic [1:0] i_row       = '0;
    logic [4:0] i_column    = '0;
    logic       o_empty;
    logic       i_pop       = 1'b0;
    logic       o_rs_pin;
    logic       o_en_pin;
    logic [7:0] o_data_pins;
    logic [6:0] o_hold_ms;
    logic       o_last;
    logic       i_cfg_we    = 1'b0;
    logic [2:0] i_cfg_idx   = '0;
    logic [0:0] i_cfg_data  = '0;

    character_lcd_bus_sequencer_core #(
        .PULSE_MS (PULSE_MS),
        .COLUMNS  (COLUMNS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_command   (i_command),
        .i_data_byte (i_data_byte),
        .i_row       (i_row),
        .i_column    (i_column),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_rs_pin    (o_rs_pin),
        .o_en_pin    (o_en_pin),
        .o_data_pins (o_data_pins),
        .o_hold_ms   (o_hold_ms),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: register image (bit i = register i), last RS and
    // data pin levels, and the bus states still owed by the block.
    // ------------------------------------------------------------------
    logic [NUM_CFG-1:0] cfg_bits = CFG_RESET;
    logic               rs_lvl   = 1'b0;
    logic [7:0]         data_lvl = '0;
    t_result            bus_states_due[$];

    t_lcd_cmd           cmds_pending[$];   // filled by the sequence, drained by the driver
    t_lcd_cmd           cmd_on_bus;        // item currently offered on the push port
    bit                 calm       = 1'b0; // no idling on either side
    int                 mismatches = 0;
    int                 cycle_cnt  = 0;
    int                 push_gap   = 0;
    int                 pop_stall  = 0;

    function automatic void add_state(logic en, logic [7:0] d, int hold);
        t_result r;
        r.rs      = rs_lvl;
        r.en      = en;
        r.data    = d;
        r.hold_ms = 7'(hold);
        r.last    = 1'b0;
        bus_states_due.push_back(r);
    endfunction

    // one EN strobe: high phase then low phase; settling goes on the low one
    function automatic void strobe_en(logic [7:0] d, int extra);
        data_lvl = d;
        add_state(1'b1, d, PULSE_MS);
        add_state(1'b0, d, PULSE_MS + extra);
    endfunction

    function automatic void send_lcd_byte(logic rs, logic [7:0] b, int extra);
        rs_lvl = rs;
        if (cfg_bits[CFG_FOUR_BIT]) begin
            strobe_en({b[7:4], 4'h0}, 0);
            strobe_en({b[3:0], 4'h0}, extra);
        end else begin
            strobe_en(b, extra);
        end
    endfunction

    // Expected bus states for one accepted command, with last on the final one.
    function automatic void predict_bus_states(t_lcd_cmd c);
        int first;
        first = bus_states_due.size();
        case (c.command)
            CMD_INIT: begin
                rs_lvl = 1'b0;
                // power-on wait, doubled in 8-bit mode
                add_state(1'b0, data_lvl,
                          cfg_bits[CFG_FOUR_BIT] ? int'(IDLE_MS) : 2 * int'(IDLE_MS));
                if (cfg_bits[CFG_FOUR_BIT]) begin
                    strobe_en(WAKE_NIBBLE, 0);
                    send_lcd_byte(1'b0, FUNC_SET_4
                                  | (8'(cfg_bits[CFG_TWO_LINES]) << 3)
                                  | (8'(cfg_bits[CFG_TALL_FONT]) << 2), 1);
                end else begin
                    send_lcd_byte(1'b0, FUNC_SET_8, 1);
                end
                send_lcd_byte(1'b0, DISP_CTRL
                              | (8'(cfg_bits[CFG_DISP_ON]) << 2)
                              | (8'(cfg_bits[CFG_CURSOR_ON]) << 1)
                              | 8'(cfg_bits[CFG_BLINK_ON]), 1);
                send_lcd_byte(1'b0, CLEAR_DISP, 2);
                send_lcd_byte(1'b0, ENTRY_MODE
                              | (8'(cfg_bits[CFG_ADDR_INC]) << 1)
                              | 8'(cfg_bits[CFG_DISP_SHIFT]), 0);
            end
            CMD_WR_INSTR: send_lcd_byte(1'b0, c.data_byte, 0);
            CMD_WR_DATA:  send_lcd_byte(1'b1, c.data_byte, 0);
            CMD_SET_POS: begin
                // out-of-range rows/columns (column 0 too) produce nothing
                if ((c.row == ROW_FIRST || c.row == ROW_SECOND) &&
                    c.column != 5'd0 && int'(c.column) <= COLUMNS)
                    send_lcd_byte(1'b0, (c.row == ROW_FIRST ? DDRAM_ROW1 : DDRAM_ROW2)
                                  + 8'(c.column) - 8'd1, 0);
            end
        endcase
        if (bus_states_due.size() > first)
            bus_states_due[bus_states_due.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued commands on the push port, with random gaps.
    // An item is taken at an edge where push is high and full is low.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else begin
            if (i_push && !o_full)
                predict_bus_states(cmd_on_bus);
            if (!i_push || !o_full) begin
                if (push_gap > 0) begin
                    push_gap--;
                    i_push <= 1'b0;
                end else if (!calm && $urandom_range(0, 5) == 0) begin
                    push_gap = $urandom_range(1, 15) - 1;
                    i_push <= 1'b0;
                end else if (cmds_pending.size() != 0) begin
                    cmd_on_bus = cmds_pending.pop_front();
                    i_command   <= cmd_on_bus.command;
                    i_data_byte <= cmd_on_bus.data_byte;
                    i_row       <= cmd_on_bus.row;
                    i_column    <= cmd_on_bus.column;
                    i_push      <= 1'b1;
                end else begin
                    i_push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: pops bus states with random stalls and checks each field
    // against the oldest expected state.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result due;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (bus_states_due.size() == 0) begin
                    $error("bus state with none due: rs=%0h en=%0h data=%0h hold=%0d last=%0h",
                           o_rs_pin, o_en_pin, o_data_pins, o_hold_ms, o_last);
                    mismatches++;
                end else begin
                    due = bus_states_due.pop_front();
                    if (o_rs_pin !== due.rs) begin
                        $error("rs_pin: expected %0h, got %0h", due.rs, o_rs_pin);
                        mismatches++;
                    end
                    if (o_en_pin !== due.en) begin
                        $error("en_pin: expected %0h, got %0h", due.en, o_en_pin);
                        mismatches++;
                    end
                    if (o_data_pins !== due.data) begin
                        $error("data_pins: expected %0h, got %0h", due.data, o_data_pins);
                        mismatches++;
                    end
                    if (o_hold_ms !== due.hold_ms) begin
                        $error("hold_ms: expected %0d, got %0d", due.hold_ms, o_hold_ms);
                        mismatches++;
                    end
                    if (o_last !== due.last) begin
                        $error("last: expected %0h, got %0h", due.last, o_last);
                        mismatches++;
                    end
                end
            end
            if (pop_stall > 0) begin
                pop_stall--;
                i_pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                pop_stall = $urandom_range(1, 15) - 1;
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == MAX_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------
    task automatic add_cmd(logic [1:0] cmd, logic [7:0] b, logic [1:0] row, logic [4:0] col);
        t_lcd_cmd c;
        c.command   = cmd;
        c.data_byte = b;
        c.row       = row;
        c.column    = col;
        cmds_pending.push_back(c);
    endtask

    // Writes all registers; only called while the block is idle.
    task automatic program_regs(logic [NUM_CFG-1:0] img);
        for (int r = 0; r < NUM_CFG; r++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(r);
            i_cfg_data <= img[r];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_bits = img;
    endtask

    // Wait until every item is taken and every expected state has come out,
    // then wait out the SETTLE period; dropped positions are never enqueued.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (cmds_pending.size() != 0 || i_push || bus_states_due.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Mostly well-formed commands; the rest is unconstrained noise.
    task automatic add_random_cmd();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            add_cmd(CMD_INIT, 8'($urandom), 2'($urandom), 5'($urandom));
        else if (sel < 38)
            add_cmd(CMD_WR_DATA, 8'($urandom), 2'($urandom), 5'($urandom));
        else if (sel < 58)
            add_cmd(CMD_WR_INSTR, 8'($urandom), 2'($urandom), 5'($urandom));
        else if (sel < 88)
            add_cmd(CMD_SET_POS, 8'($urandom), 2'($urandom_range(1, 2)),
                    5'($urandom_range(1, COLUMNS)));
        else
            add_cmd(2'($urandom), 8'($urandom), 2'($urandom), 5'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset register image, 4-bit bus: extremes and every position case
        program_regs(CFG_RESET);
        add_cmd(CMD_INIT,     8'h00, 2'd0, 5'd0);
        add_cmd(CMD_WR_INSTR, 8'h00, 2'd3, 5'd31);
        add_cmd(CMD_WR_INSTR, 8'hFF, 2'd0, 5'd0);
        add_cmd(CMD_WR_DATA,  8'hA5, 2'd1, 5'd10);
        add_cmd(CMD_WR_DATA,  8'h5A, 2'd2, 5'd21);
        add_cmd(CMD_SET_POS,  8'hFF, ROW_FIRST, 5'd1);
        add_cmd(CMD_SET_POS,  8'h00, ROW_FIRST, 5'(COLUMNS));
        add_cmd(CMD_SET_POS,  8'h3C, ROW_SECOND, 5'd1);
        add_cmd(CMD_SET_POS,  8'hC3, ROW_SECOND, 5'(COLUMNS));
        // out of range: bad rows, column zero, column past the display
        add_cmd(CMD_SET_POS,  8'h12, 2'd0, 5'd5);
        add_cmd(CMD_SET_POS,  8'h34, 2'd3, 5'd5);
        add_cmd(CMD_SET_POS,  8'h56, ROW_FIRST, 5'd0);
        add_cmd(CMD_SET_POS,  8'h78, ROW_SECOND, 5'(COLUMNS + 1));
        add_cmd(CMD_SET_POS,  8'h9A, ROW_FIRST, 5'd31);
        wait_idle();

        // 8-bit bus, all other bits set
        program_regs(~(NUM_CFG'(1) << CFG_FOUR_BIT));
        add_cmd(CMD_INIT,     8'h00, 2'd0, 5'd0);
        add_cmd(CMD_WR_DATA,  8'hFF, 2'd0, 5'd0);
        add_cmd(CMD_WR_INSTR, 8'h00, 2'd3, 5'd31);
        add_cmd(CMD_SET_POS,  8'h00, ROW_SECOND, 5'(COLUMNS));
        wait_idle();

        // everything cleared
        program_regs('0);
        add_cmd(CMD_INIT,     8'hFF, 2'd3, 5'd31);
        add_cmd(CMD_WR_DATA,  8'h81, 2'd0, 5'd0);
        add_cmd(CMD_SET_POS,  8'h00, ROW_FIRST, 5'd1);
        wait_idle();

        // everything set, 4-bit bus
        program_regs('1);
        add_cmd(CMD_INIT,     8'h00, 2'd0, 5'd0);
        add_cmd(CMD_WR_DATA,  8'h3C, 2'd0, 5'd0);
        wait_idle();

        // random register images; a phase need not start with init, so
        // mode changes without re-init are covered too
        for (int p = 0; p < RAND_PHASES; p++) begin
            program_regs(NUM_CFG'($urandom));
            calm = (p == RAND_PHASES - 1);
            for (int k = 0; k < RAND_ITEMS; k++)
                add_random_cmd();
            wait_idle();
        end

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/lbs_pkg.sv
hdl/lbs_fifo.sv
hdl/lbs_front.sv
hdl/lbs_back.sv
hdl/character_lcd_bus_sequencer_core.sv
hdl/lbs_checker.sv
tb/tb_top.sv
